FILE: sv/wlvs_pkg.sv
// wlvs_pkg: shared constants, types and helpers for window_level_variance_shift.
// No dependencies; every other file of the block but wlvs_ram imports this package.
package wlvs_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_LENGTH  = 1048576;
    localparam int SAMPLE_BITS = 16;

    localparam int WIDTH_W  = 7;                        // config register
    localparam int PTR_W    = $clog2(MAX_WIDTH);        // ring address
    localparam int COUNT_W  = $clog2(MAX_LENGTH) + 1;   // holds MAX_LENGTH + 1
    localparam int INDEX_W  = 20;
    localparam int SQ_W     = 2 * SAMPLE_BITS - 1;      // one squared sample
    localparam int SUM_W    = 23;
    localparam int ABS_W    = SUM_W - 1;
    localparam int QSUM_W   = 37;
    localparam int SPREAD_W = 43;
    localparam int LEVEL_W  = 23;
    localparam int LEVEL_OUT_W = 22;
    localparam int OUT_BITS = LEVEL_OUT_W + INDEX_W + 1 + SPREAD_W + INDEX_W + 3;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(10);
    localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(2);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_LENGTH);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
        logic [SQ_W-1:0]               square;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUMS,
        ST_MUL,
        ST_SPREAD,
        ST_CMP,
        ST_RESULT
    } back_state_t;

    // magnitude of a two's complement sample, full range fits unsigned
    function automatic logic [SAMPLE_BITS-1:0] sample_mag(logic signed [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS-1:0] r;
        r = v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
        return r;
    endfunction

endpackage

FILE: sv/wlvs_ram.sv
// wlvs_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module wlvs_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/wlvs_front.sv
// wlvs_front: input stage; registers each sample beat and squares it ahead of the back end.
// Depends on wlvs_pkg.
module wlvs_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wlvs_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    output logic                            q_valid,
    input  logic                            q_ready,
    output wlvs_pkg::item_t                 q_item
);
    import wlvs_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic [SAMPLE_BITS-1:0]        in_mag;
    logic [2*SAMPLE_BITS-1:0]      in_square;
    logic                          take;

    assign in_sample = s_tdata[SAMPLE_BITS-1:0];
    assign in_mag    = sample_mag(in_sample);
    assign in_square = in_mag * in_mag;

    assign s_tready = !valid_reg || q_ready;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (q_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.sample <= in_sample;
            item_reg.last   <= s_tlast;
            item_reg.square <= in_square[SQ_W-1:0];
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

FILE: sv/wlvs_queue.sv
// wlvs_queue: short FIFO of sample items between the front stage and the back end.
// Depends on wlvs_pkg.
module wlvs_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  wlvs_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output wlvs_pkg::item_t out_item
);
    import wlvs_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]  wr_ptr_reg;
    logic [QP_W-1:0]  rd_ptr_reg;
    logic [QC_W-1:0]  count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != QC_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: sv/wlvs_back.sv
// wlvs_back: sequencer that updates the window sums, spreads and best shifts per sample,
// and forms the result on the last sample. Depends on wlvs_pkg and wlvs_ram.
module wlvs_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_write,
    input  logic [wlvs_pkg::WIDTH_W-1:0]    cfg_width,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  wlvs_pkg::item_t                 q_item,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wlvs_pkg::OUT_DATA_W-1:0] m_tdata
);
    import wlvs_pkg::*;

    typedef struct packed {
        logic pop;
        logic rd_en;
        logic ring_wr;
        logic hist_wr;
        logic load_out;
    } back_ctrl_t;

    back_state_t state_reg, state_next;
    back_ctrl_t  ctrl;

    logic [WIDTH_W-1:0]            width_reg;
    logic [COUNT_W-1:0]            count_reg;
    logic [PTR_W-1:0]              ptr_reg;
    logic signed [SUM_W-1:0]       wsum_reg;
    logic [QSUM_W-1:0]             qsum_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [SQ_W-1:0]               sq_reg;
    logic                          last_reg;
    logic [SQ_W-1:0]               old_sq_reg;
    logic [ABS_W-1:0]              abs_sum_reg;
    logic [SPREAD_W-1:0]           wq_reg;
    logic [SPREAD_W-1:0]           s2_reg;
    logic [SPREAD_W-1:0]           spread_reg;
    logic [LEVEL_W-1:0]            dl_reg;
    logic [LEVEL_W-1:0]            best_level_reg;
    logic [INDEX_W-1:0]            best_level_idx_reg;
    logic                          best_level_seen_reg;
    logic [SPREAD_W-1:0]           best_spread_reg;
    logic [INDEX_W-1:0]            best_spread_idx_reg;
    logic                          best_spread_seen_reg;
    logic                          m_valid_reg;
    logic [OUT_DATA_W-1:0]         m_data_reg;
    logic [OUT_DATA_W-1:0]         m_data_next;

    logic signed [SAMPLE_BITS-1:0] ring_rd;
    logic [SUM_W-1:0]              sum_hist_rd;
    logic [SPREAD_W-1:0]           spread_hist_rd;

    logic                          saturated;
    logic                          drop_old;
    logic                          window_full;
    logic                          compare_on;
    logic [COUNT_W-1:0]            count_inc;
    logic [SAMPLE_BITS-1:0]        old_mag;
    logic [2*SAMPLE_BITS-1:0]      old_square;
    logic signed [SUM_W-1:0]       wsum_sub;
    logic [QSUM_W-1:0]             qsum_sub;
    logic [WIDTH_W+QSUM_W-1:0]     wq_full;
    logic [2*ABS_W-1:0]            s2_full;
    logic signed [SUM_W:0]         level_diff;
    logic [SPREAD_W-1:0]           dv;
    logic [PTR_W:0]                ptr_inc;
    logic                          too_short;
    logic                          too_long;
    logic [WIDTH_W-1:0]            width_clamped;
    logic                          out_free;

    wlvs_ram #(.DATA_W(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_ring (
        .aclk    (aclk),
        .wr_en   (ctrl.ring_wr),
        .wr_addr (ptr_reg),
        .wr_data (x_reg),
        .rd_en   (ctrl.rd_en),
        .rd_addr (ptr_reg),
        .rd_data (ring_rd)
    );

    wlvs_ram #(.DATA_W(SUM_W), .DEPTH(MAX_WIDTH)) u_sum_hist (
        .aclk    (aclk),
        .wr_en   (ctrl.hist_wr),
        .wr_addr (ptr_reg),
        .wr_data (wsum_reg),
        .rd_en   (ctrl.rd_en),
        .rd_addr (ptr_reg),
        .rd_data (sum_hist_rd)
    );

    wlvs_ram #(.DATA_W(SPREAD_W), .DEPTH(MAX_WIDTH)) u_spread_hist (
        .aclk    (aclk),
        .wr_en   (ctrl.hist_wr),
        .wr_addr (ptr_reg),
        .wr_data (spread_reg),
        .rd_en   (ctrl.rd_en),
        .rd_addr (ptr_reg),
        .rd_data (spread_hist_rd)
    );

    // count_reg is t while a sample is in flight
    assign saturated   = count_reg >= COUNT_LIMIT;
    assign drop_old    = count_reg >= COUNT_W'(width_reg);
    assign count_inc   = count_reg + 1'b1;
    assign window_full = count_inc >= COUNT_W'(width_reg);
    assign compare_on  = count_inc >= COUNT_W'({width_reg, 1'b0});

    assign old_mag    = sample_mag(ring_rd);
    assign old_square = old_mag * old_mag;
    assign wsum_sub   = drop_old ? SUM_W'(ring_rd) : '0;
    assign qsum_sub   = drop_old ? QSUM_W'(old_sq_reg) : '0;
    assign wq_full    = width_reg * qsum_reg;
    assign s2_full    = abs_sum_reg * abs_sum_reg;
    assign level_diff = (SUM_W+1)'(wsum_reg) - (SUM_W+1)'($signed(sum_hist_rd));
    assign dv         = (spread_reg >= spread_hist_rd) ? spread_reg - spread_hist_rd
                                                      : spread_hist_rd - spread_reg;
    assign ptr_inc    = (PTR_W+1)'(ptr_reg) + 1'b1;

    // after the increment count_reg is the number of samples taken
    assign too_long  = count_reg > COUNT_LIMIT;
    assign too_short = count_reg < COUNT_W'({width_reg, 1'b0});
    assign out_free  = !m_valid_reg || m_tready;

    always_comb begin
        if (cfg_width < WIDTH_MIN) begin
            width_clamped = WIDTH_MIN;
        end else if (cfg_width > WIDTH_MAX) begin
            width_clamped = WIDTH_MAX;
        end else begin
            width_clamped = cfg_width;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (!saturated) begin
                        state_next = ST_READ;
                    end else if (q_item.last) begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_READ:   state_next = ST_SUMS;
            ST_SUMS:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_SPREAD;
            ST_SPREAD: state_next = ST_CMP;
            ST_CMP:    state_next = last_reg ? ST_RESULT : ST_IDLE;
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE: begin
                ctrl.pop   = 1'b1;
                ctrl.rd_en = q_valid && !saturated;
            end
            ST_SUMS:   ctrl.ring_wr  = 1'b1;
            ST_CMP:    ctrl.hist_wr  = window_full;
            ST_RESULT: ctrl.load_out = out_free;
            default:   ctrl = '0;
        endcase
    end

    assign q_ready = ctrl.pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else if (cfg_write) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
        end else if (cfg_write) begin
            width_reg <= width_clamped;
        end
    end

    // series state
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_write || ctrl.load_out) begin
            count_reg            <= '0;
            ptr_reg              <= '0;
            wsum_reg             <= '0;
            qsum_reg             <= '0;
            best_level_reg       <= '0;
            best_level_idx_reg   <= '0;
            best_level_seen_reg  <= 1'b0;
            best_spread_reg      <= '0;
            best_spread_idx_reg  <= '0;
            best_spread_seen_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid && saturated) begin
                        count_reg <= COUNT_LIMIT + 1'b1;
                    end
                end
                ST_READ: begin
                    wsum_reg <= wsum_reg - wsum_sub + SUM_W'(x_reg);
                end
                ST_SUMS: begin
                    qsum_reg <= qsum_reg - qsum_sub + QSUM_W'(sq_reg);
                end
                ST_CMP: begin
                    if (window_full && compare_on) begin
                        if (dl_reg > best_level_reg) begin
                            best_level_reg      <= dl_reg;
                            best_level_idx_reg  <= count_reg[INDEX_W-1:0];
                            best_level_seen_reg <= 1'b1;
                        end
                        if (dv > best_spread_reg) begin
                            best_spread_reg      <= dv;
                            best_spread_idx_reg  <= count_reg[INDEX_W-1:0];
                            best_spread_seen_reg <= 1'b1;
                        end
                    end
                    ptr_reg   <= (ptr_inc == (PTR_W+1)'(width_reg)) ? '0 : ptr_inc[PTR_W-1:0];
                    count_reg <= count_inc;
                end
                default: begin
                end
            endcase
        end
    end

    // per-sample payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            x_reg    <= q_item.sample;
            sq_reg   <= q_item.square;
            last_reg <= q_item.last;
        end
        if (state_reg == ST_READ) begin
            old_sq_reg <= old_square[SQ_W-1:0];
        end
        if (state_reg == ST_SUMS) begin
            abs_sum_reg <= wsum_reg[SUM_W-1] ? ABS_W'(-wsum_reg) : ABS_W'(wsum_reg);
        end
        if (state_reg == ST_MUL) begin
            wq_reg <= wq_full[SPREAD_W-1:0];
            s2_reg <= s2_full[SPREAD_W-1:0];
        end
        if (state_reg == ST_SPREAD) begin
            spread_reg <= wq_reg - s2_reg;
            dl_reg     <= level_diff[SUM_W] ? LEVEL_W'(-level_diff) : LEVEL_W'(level_diff);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        m_data_next = '0;
        if (!too_short) begin
            m_data_next[OUT_BITS-3:0] = {best_spread_seen_reg, best_spread_idx_reg,
                                         best_spread_reg, best_level_seen_reg,
                                         best_level_idx_reg,
                                         best_level_reg[LEVEL_OUT_W-1:0]};
        end
        m_data_next[OUT_BITS-2] = too_short;
        m_data_next[OUT_BITS-1] = too_long;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: sv/window_level_variance_shift.sv
// window_level_variance_shift: top level; front stage, item queue and back-end sequencer.
// Depends on wlvs_pkg, wlvs_front, wlvs_queue, wlvs_back (which uses wlvs_ram).
//
// Streams signed samples in on s_*, one per beat, with s_tlast on the last sample of a series,
// and emits one result beat on m_* for each series. Width of the rolling window comes from
// cfg_data (clamped to 2..64) and a write resets the series; write it only while the block is
// idle. Each sample passes through the back-end sequencer steps in order (ring read, sum update,
// square-sum update, the two spread multiplies, spread/level difference, compare and history
// write); a series' last sample then loads the result register once the output is free. Samples
// beyond the length limit are dropped unprocessed. The front stage and a four-entry queue
// take input beats while the back end works and while a result waits on m_tready.
module window_level_variance_shift (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wlvs_pkg::WIDTH_W-1:0]    cfg_data,     // window_width
    // sample input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wlvs_pkg::IN_DATA_W-1:0]  s_tdata,      // [15:0] sample
    input  logic                            s_tlast,      // last_sample
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [21:0] level_shift_scaled, [41:22] level_shift_index, [42] level_found,
    // [85:43] variance_shift_scaled, [105:86] variance_shift_index, [106] variance_found,
    // [107] series_too_short, [108] series_too_long, [111:109] zero
    output logic [wlvs_pkg::OUT_DATA_W-1:0] m_tdata
);
    import wlvs_pkg::*;

    logic  fq_valid;
    logic  fq_ready;
    item_t fq_item;
    logic  qb_valid;
    logic  qb_ready;
    item_t qb_item;

    assign cfg_ready = 1'b1;

    wlvs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    wlvs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    wlvs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_width (cfg_data),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_item    (qb_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
